// ----- rtl/sdspi_pkg.sv -----
// Package with codes, constants and types for the SD card SPI controller.
`default_nettype none
package sdspi_pkg;
  localparam int SectorBytes = 512;

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_WBEGIN = 3'd2;
  localparam logic [2:0] OP_WBYTE = 3'd3;
  localparam logic [2:0] OP_WFINISH = 3'd4;
  localparam logic [2:0] OP_RX = 3'd5;

  localparam logic [2:0] CFG_RESP = 3'd0;
  localparam logic [2:0] CFG_V2 = 3'd1;
  localparam logic [2:0] CFG_V1 = 3'd2;
  localparam logic [2:0] CFG_TOKEN = 3'd3;
  localparam logic [2:0] CFG_BUSY = 3'd4;

  localparam logic [7:0] CMD0 = 8'h40;
  localparam logic [7:0] CMD1 = 8'h41;
  localparam logic [7:0] CMD8 = 8'h48;
  localparam logic [7:0] CMD16 = 8'h50;
  localparam logic [7:0] CMD17 = 8'h51;
  localparam logic [7:0] CMD24 = 8'h58;
  localparam logic [7:0] CMD55 = 8'h77;
  localparam logic [7:0] CMD58 = 8'h7A;
  localparam logic [7:0] ACMD41 = 8'hE9;

  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_WOPEN = 4'd1;
  localparam logic [3:0] P_DUMMY = 4'd2;
  localparam logic [3:0] P_CMD = 4'd3;
  localparam logic [3:0] P_RESP = 4'd4;
  localparam logic [3:0] P_R7 = 4'd5;
  localparam logic [3:0] P_OCR = 4'd6;
  localparam logic [3:0] P_TOKEN = 4'd7;
  localparam logic [3:0] P_DATA = 4'd8;
  localparam logic [3:0] P_WHDR = 4'd9;
  localparam logic [3:0] P_WBYTE = 4'd10;
  localparam logic [3:0] P_WPAD = 4'd11;
  localparam logic [3:0] P_WRESP = 4'd12;
  localparam logic [3:0] P_BUSY = 4'd13;
  localparam logic [3:0] P_REL = 4'd14;

  localparam logic [3:0] R_NONE = 4'd0;
  localparam logic [3:0] R_CMD0 = 4'd1;
  localparam logic [3:0] R_CMD8 = 4'd2;
  localparam logic [3:0] R_V2 = 4'd3;
  localparam logic [3:0] R_CMD58 = 4'd4;
  localparam logic [3:0] R_PROBE = 4'd5;
  localparam logic [3:0] R_V1 = 4'd6;
  localparam logic [3:0] R_CMD16 = 4'd7;
  localparam logic [3:0] R_READ = 4'd8;
  localparam logic [3:0] R_WBEGIN = 4'd9;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_NOINIT = 2'd2;
  localparam logic [1:0] ST_BUSY = 2'd3;

  localparam logic [2:0] CT_NONE = 3'd0;
  localparam logic [2:0] CT_SDV2B = 3'd4;

  typedef struct packed {
    logic [7:0] resp;
    logic [15:0] v2;
    logic [15:0] v1;
    logic [15:0] token;
    logic [15:0] busy;
  } cfg_t;

  typedef struct packed {
    logic [2:0] op;
    logic [31:0] block_address;
    logic [8:0] byte_offset;
    logic [9:0] byte_count;
    logic [7:0] write_byte;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic tx_valid;
    logic [7:0] tx_byte;
    logic card_selected;
    logic read_valid;
    logic [7:0] read_byte;
    logic done_res;
    logic [1:0] status;
    logic [2:0] card_type;
  } res_t;
endpackage
`default_nettype wire

// ----- rtl/sd_card_spi_controller.sv -----
// Top level of the SD card SPI controller with input and result registers.
// Each word's result appears in the cycle after the word is taken, from a
// result register; one result register and no input register let
// back-to-back words sustain one word per cycle while the output accepts.
// A stalled output holds at most one word, so the input stays ready while
// the result register is empty or is being taken.
`default_nettype none
module sd_card_spi_controller import sdspi_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[2:0], block_address[34:3], byte_offset[43:35], byte_count[53:44],
  // write_byte[61:54], rx_byte[69:62], zero fill up to 71
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tx_valid[0], tx_byte[8:1], card_selected[9], read_valid[10],
  // read_byte[18:11], done_res[19], status[21:20], card_type[24:22], zero fill
  output logic [31:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  cfg_t cfg;
  item_t item;
  res_t res, res_q;
  logic step, out_v_q;

  assign s_axis_tready = !out_v_q || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;
  assign item = '{op: s_axis_tdata[2:0], block_address: s_axis_tdata[34:3],
                  byte_offset: s_axis_tdata[43:35], byte_count: s_axis_tdata[53:44],
                  write_byte: s_axis_tdata[61:54], rx_byte: s_axis_tdata[69:62]};

  sdspi_cfg u_cfg (.clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg));
  sdspi_core u_core (.clk_i, .rst_ni, .step_i(step), .item_i(item), .cfg_i(cfg),
                     .res_o(res));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (s_axis_tready) out_v_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {7'd0, res_q.card_type, res_q.status, res_q.done_res,
                         res_q.read_byte, res_q.read_valid, res_q.card_selected,
                         res_q.tx_byte, res_q.tx_valid};
endmodule
`default_nettype wire

// ----- rtl/sdspi_cfg.sv -----
// Configuration register file for the SD card SPI controller.
`default_nettype none
module sdspi_cfg import sdspi_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output cfg_t             cfg_o
);
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{resp: 8'd10, v2: 16'd12000, v1: 16'd25000, token: 16'd30000,
                 busy: 16'd65000};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RESP:  cfg_q.resp <= cfg_data_i[7:0];
        CFG_V2:    cfg_q.v2 <= cfg_data_i;
        CFG_V1:    cfg_q.v1 <= cfg_data_i;
        CFG_TOKEN: cfg_q.token <= cfg_data_i;
        CFG_BUSY:  cfg_q.busy <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

// ----- rtl/sdspi_core.sv -----
// Protocol state and next-state logic for one word per cycle, advancing only on accepted words.
`default_nettype none
module sdspi_core import sdspi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  item_t     item_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);
  logic [3:0] phase_q, phase_d, ret_q, ret_d;
  logic [2:0] dtype_q, dtype_d, trial_q, trial_d, pidx_q, pidx_d;
  logic [9:0] wrem_q, wrem_d, skip_q, skip_d, dlv_q, dlv_d, trail_q, trail_d;
  logic [15:0] retry_q, retry_d;
  logic [7:0] poll_q, poll_d, ccode_q, ccode_d, acode_q, acode_d, lcode_q, lcode_d;
  logic [31:0] carg_q, carg_d, aarg_q, aarg_d, ocr_q, ocr_d;
  logic sel_q, sel_d, app_q, app_d;
  logic [1:0] est_q, est_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE; ret_q <= R_NONE; dtype_q <= CT_NONE; trial_q <= '0;
      pidx_q <= '0; wrem_q <= '0; skip_q <= '0; dlv_q <= '0; trail_q <= '0;
      retry_q <= '0; poll_q <= '0; ccode_q <= '0; acode_q <= '0; lcode_q <= '0;
      carg_q <= '0; aarg_q <= '0; ocr_q <= '0; sel_q <= 1'b0; app_q <= 1'b0;
      est_q <= ST_OK;
    end else if (step_i) begin
      phase_q <= phase_d; ret_q <= ret_d; dtype_q <= dtype_d; trial_q <= trial_d;
      pidx_q <= pidx_d; wrem_q <= wrem_d; skip_q <= skip_d; dlv_q <= dlv_d;
      trail_q <= trail_d; retry_q <= retry_d; poll_q <= poll_d; ccode_q <= ccode_d;
      acode_q <= acode_d; lcode_q <= lcode_d; carg_q <= carg_d; aarg_q <= aarg_d;
      ocr_q <= ocr_d; sel_q <= sel_d; app_q <= app_d; est_q <= est_d;
    end
  end

  always_comb begin
    logic txv, rv, dn;
    logic [7:0] tx, rd, rx, pb;
    logic [1:0] st;
    logic [31:0] addr, ocrn;
    logic [9:0] ofs, sk, dl, tr, tdec;
    logic [10:0] sum;
    logic [15:0] rdec;
    logic [7:0] pdec;
    logic [2:0] pinc;
    logic resp_go;
    logic [7:0] rr;
    logic [7:0] bc_code;
    logic [31:0] bc_arg;
    logic [3:0] bc_ret;
    logic bc_go, sp_go, fi_go, rel_go;
    logic [7:0] sp_code;
    logic [31:0] sp_arg;
    logic [2:0] fi_t;
    logic [1:0] rel_st;
    phase_d = phase_q; ret_d = ret_q; dtype_d = dtype_q; trial_d = trial_q;
    pidx_d = pidx_q; wrem_d = wrem_q; skip_d = skip_q; dlv_d = dlv_q;
    trail_d = trail_q; retry_d = retry_q; poll_d = poll_q; ccode_d = ccode_q;
    acode_d = acode_q; lcode_d = lcode_q; carg_d = carg_q; aarg_d = aarg_q;
    ocr_d = ocr_q; sel_d = sel_q; app_d = app_q; est_d = est_q;
    txv = 1'b0; tx = 8'h00; rv = 1'b0; rd = 8'h00; dn = 1'b0; st = ST_OK;
    rx = item_i.rx_byte;
    resp_go = 1'b0; rr = rx;
    bc_go = 1'b0; bc_code = '0; bc_arg = '0; bc_ret = R_NONE;
    sp_go = 1'b0; sp_code = '0; sp_arg = '0;
    fi_go = 1'b0; fi_t = CT_NONE; rel_go = 1'b0; rel_st = ST_OK;
    addr = (dtype_q == CT_SDV2B) ? item_i.block_address
                                 : {item_i.block_address[22:0], 9'd0};
    ocrn = {ocr_q[23:0], rx};
    rdec = retry_q - 16'd1; pdec = poll_q - 8'd1; tdec = trail_q - 10'd1;
    pinc = pidx_q + 3'd1;
    ofs = {1'b0, item_i.byte_offset};
    sum = {2'b00, item_i.byte_offset} + {1'b0, item_i.byte_count};
    unique case (pinc)
      3'd2: pb = ccode_q;
      3'd3: pb = carg_q[31:24];
      3'd4: pb = carg_q[23:16];
      3'd5: pb = carg_q[15:8];
      3'd6: pb = carg_q[7:0];
      3'd7: pb = (ccode_q == CMD0) ? 8'h95 : ((ccode_q == CMD8) ? 8'h87 : 8'h01);
      default: pb = 8'hFF;
    endcase
    sk = skip_q; dl = dlv_q; tr = trail_q;

    if (item_i.op == OP_RX) begin
      unique case (phase_q)
        P_DUMMY: begin
          trail_d = tdec;
          if (tdec == '0) begin
            bc_go = 1'b1; bc_code = CMD0; bc_ret = R_CMD0;
          end else begin
            txv = 1'b1; tx = 8'hFF;
          end
        end
        P_CMD: begin
          pidx_d = pinc;
          if (pidx_q == 3'd7) begin
            phase_d = P_RESP; poll_d = cfg_i.resp; txv = 1'b1; tx = 8'hFF;
          end else begin
            if (pinc == 3'd1) sel_d = 1'b1;
            txv = 1'b1; tx = pb;
          end
        end
        P_RESP: begin
          if (rx[7] && pdec != '0) begin
            poll_d = pdec; txv = 1'b1; tx = 8'hFF;
          end else begin
            if (rx[7]) poll_d = pdec;
            if (app_q) begin
              app_d = 1'b0;
              if (rx > 8'd1) resp_go = 1'b1;
              else begin
                sp_go = 1'b1; sp_code = acode_q; sp_arg = aarg_q;
              end
            end else resp_go = 1'b1;
          end
        end
        P_R7, P_OCR: begin
          ocr_d = ocrn; pidx_d = pinc;
          if (pinc < 3'd4) begin
            txv = 1'b1; tx = 8'hFF;
          end else if (phase_q == P_OCR) begin
            fi_go = 1'b1; fi_t = ocrn[30] ? 3'd4 : 3'd3;
          end else if (ocrn[15:0] == 16'h01AA) begin
            retry_d = cfg_i.v2;
            bc_go = 1'b1; bc_code = ACMD41; bc_arg = 32'h4000_0000; bc_ret = R_V2;
          end else fi_go = 1'b1;
        end
        P_TOKEN: begin
          if (rx == 8'hFE) begin
            phase_d = P_DATA; txv = 1'b1; tx = 8'hFF;
          end else if (rx != 8'hFF) begin
            rel_go = 1'b1; rel_st = ST_ERR;
          end else begin
            retry_d = rdec;
            if (rdec == '0) begin
              rel_go = 1'b1; rel_st = ST_ERR;
            end else begin
              txv = 1'b1; tx = 8'hFF;
            end
          end
        end
        P_DATA: begin
          if (sk != '0) sk = sk - 10'd1;
          else if (dl != '0) begin
            dl = dl - 10'd1; rv = 1'b1; rd = rx;
          end else if (tr != '0) tr = tr - 10'd1;
          skip_d = sk; dlv_d = dl; trail_d = tr;
          if (sk == '0 && dl == '0 && tr == '0) begin
            rel_go = 1'b1; rel_st = ST_OK;
          end else begin
            txv = 1'b1; tx = 8'hFF;
          end
        end
        P_WHDR: begin
          if (pidx_q == '0) begin
            pidx_d = 3'd1; txv = 1'b1; tx = 8'hFE;
          end else begin
            wrem_d = 10'(SectorBytes); phase_d = P_WOPEN; dn = 1'b1; st = ST_OK;
          end
        end
        P_WBYTE: begin
          phase_d = P_WOPEN; dn = 1'b1; st = ST_OK;
        end
        P_WPAD: begin
          trail_d = tdec;
          if (tdec == '0) phase_d = P_WRESP;
          txv = 1'b1; tx = (tdec == '0) ? 8'hFF : 8'h00;
        end
        P_WRESP: begin
          if (rx[4:0] == 5'h05) begin
            phase_d = P_BUSY; retry_d = cfg_i.busy; txv = 1'b1; tx = 8'hFF;
          end else begin
            rel_go = 1'b1; rel_st = ST_ERR;
          end
        end
        P_BUSY: begin
          if (rx == 8'hFF) begin
            rel_go = 1'b1; rel_st = ST_OK;
          end else begin
            retry_d = rdec;
            if (rdec == '0) begin
              rel_go = 1'b1; rel_st = ST_ERR;
            end else begin
              txv = 1'b1; tx = 8'hFF;
            end
          end
        end
        P_REL: begin
          phase_d = P_IDLE; dn = 1'b1; st = est_q;
        end
        default: ;
      endcase
    end else if (item_i.op <= OP_WFINISH) begin
      if (phase_q != P_IDLE && phase_q != P_WOPEN) begin
        dn = 1'b1; st = ST_BUSY;
      end else begin
        unique case (item_i.op)
          OP_INIT: begin
            wrem_d = '0; sel_d = 1'b0; trail_d = 10'd11; phase_d = P_DUMMY;
            txv = 1'b1; tx = 8'hFF;
          end
          OP_READ, OP_WBEGIN: begin
            if (phase_q == P_WOPEN) begin
              dn = 1'b1; st = ST_BUSY;
            end else if (dtype_q == CT_NONE) begin
              dn = 1'b1; st = ST_NOINIT;
            end else if (item_i.op == OP_READ) begin
              if (item_i.byte_count == '0 || sum > 11'(SectorBytes)) begin
                dn = 1'b1; st = ST_ERR;
              end else begin
                skip_d = ofs; dlv_d = item_i.byte_count;
                trail_d = 10'(11'(SectorBytes + 2) - sum);
                bc_go = 1'b1; bc_code = CMD17; bc_arg = addr; bc_ret = R_READ;
              end
            end else begin
              bc_go = 1'b1; bc_code = CMD24; bc_arg = addr; bc_ret = R_WBEGIN;
            end
          end
          OP_WBYTE: begin
            if (phase_q != P_WOPEN) begin
              dn = 1'b1; st = ST_ERR;
            end else if (wrem_q == '0) begin
              dn = 1'b1; st = ST_OK;
            end else begin
              wrem_d = wrem_q - 10'd1; phase_d = P_WBYTE;
              txv = 1'b1; tx = item_i.write_byte;
            end
          end
          default: begin
            if (phase_q != P_WOPEN) begin
              dn = 1'b1; st = ST_ERR;
            end else begin
              trail_d = wrem_q + 10'd2; wrem_d = '0; phase_d = P_WPAD;
              txv = 1'b1; tx = 8'h00;
            end
          end
        endcase
      end
    end

    if (resp_go) begin
      unique case (ret_q)
        R_CMD0: begin
          if (rr == 8'd1) begin
            bc_go = 1'b1; bc_code = CMD8; bc_arg = 32'h1AA; bc_ret = R_CMD8;
          end else fi_go = 1'b1;
        end
        R_CMD8: begin
          if (rr == 8'd1) begin
            phase_d = P_R7; pidx_d = '0; txv = 1'b1; tx = 8'hFF;
          end else begin
            bc_go = 1'b1; bc_code = ACMD41; bc_ret = R_PROBE;
          end
        end
        R_V2: begin
          if (rr == 8'd0) begin
            bc_go = 1'b1; bc_code = CMD58; bc_ret = R_CMD58;
          end else begin
            retry_d = rdec;
            if (rdec == '0) fi_go = 1'b1;
            else begin
              bc_go = 1'b1; bc_code = ACMD41; bc_arg = 32'h4000_0000; bc_ret = R_V2;
            end
          end
        end
        R_CMD58: begin
          if (rr == 8'd0) begin
            phase_d = P_OCR; pidx_d = '0; txv = 1'b1; tx = 8'hFF;
          end else fi_go = 1'b1;
        end
        R_PROBE: begin
          trial_d = (rr <= 8'd1) ? 3'd2 : 3'd1;
          lcode_d = (rr <= 8'd1) ? ACMD41 : CMD1;
          retry_d = cfg_i.v1;
          bc_go = 1'b1; bc_code = lcode_d; bc_ret = R_V1;
        end
        R_V1: begin
          if (rr == 8'd0) begin
            bc_go = 1'b1; bc_code = CMD16; bc_arg = 32'(SectorBytes); bc_ret = R_CMD16;
          end else begin
            retry_d = rdec;
            if (rdec == '0) fi_go = 1'b1;
            else begin
              bc_go = 1'b1; bc_code = lcode_q; bc_ret = R_V1;
            end
          end
        end
        R_CMD16: begin
          fi_go = 1'b1; fi_t = (rr == 8'd0) ? trial_q : CT_NONE;
        end
        R_READ: begin
          if (rr == 8'd0) begin
            phase_d = P_TOKEN; retry_d = cfg_i.token; txv = 1'b1; tx = 8'hFF;
          end else begin
            rel_go = 1'b1; rel_st = ST_ERR;
          end
        end
        R_WBEGIN: begin
          if (rr == 8'd0) begin
            phase_d = P_WHDR; pidx_d = '0; txv = 1'b1; tx = 8'hFF;
          end else begin
            phase_d = P_IDLE; dn = 1'b1; st = ST_ERR;
          end
        end
        default: begin
          phase_d = P_IDLE; dn = 1'b1; st = ST_ERR;
        end
      endcase
    end

    if (bc_go) begin
      ret_d = bc_ret;
      if (bc_code[7]) begin
        app_d = 1'b1; acode_d = {1'b0, bc_code[6:0]}; aarg_d = bc_arg;
        sp_go = 1'b1; sp_code = CMD55; sp_arg = '0;
      end else begin
        app_d = 1'b0; sp_go = 1'b1; sp_code = bc_code; sp_arg = bc_arg;
      end
    end
    if (sp_go) begin
      ccode_d = sp_code; carg_d = sp_arg; pidx_d = '0; phase_d = P_CMD;
      sel_d = 1'b0; txv = 1'b1; tx = 8'hFF;
    end
    if (fi_go) begin
      dtype_d = fi_t; rel_go = 1'b1; rel_st = (fi_t != CT_NONE) ? ST_OK : ST_NOINIT;
    end
    if (rel_go) begin
      est_d = rel_st; sel_d = 1'b0; phase_d = P_REL; txv = 1'b1; tx = 8'hFF;
    end

    res_o.tx_valid = txv; res_o.tx_byte = tx; res_o.card_selected = sel_d;
    res_o.read_valid = rv; res_o.read_byte = rd; res_o.done_res = dn;
    res_o.status = st; res_o.card_type = dtype_d;
  end
endmodule
`default_nettype wire

// ----- rtl/sdspi_checker.sv -----
// Port-level assertions for the SD card SPI controller and their binding.
`default_nettype none
module sdspi_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input stalled with empty output");
  a_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid) else $error("word lost");
  a_tx0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[8:1] == 8'h00)
    else $error("tx byte not zero");
  a_st0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[19]) |-> m_axis_tdata[21:20] == 2'd0)
    else $error("status not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
endmodule

bind sd_card_spi_controller sdspi_checker u_sdspi_checker (.*);
`default_nettype wire
